// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sigmoid activation unit.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define SAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside of reset.
`define SAU_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SAU_ASSERT(label, prop, msg)
`define SAU_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- rtl/sau_pkg.sv -----
// Package for the sigmoid activation unit: formats, widths, operation codes, lane beat
// type and the sigmoid lookup table. No dependencies.
package sau_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FRAC_BITS     = 12;
    localparam int DATA_W        = 16;
    localparam int SEG_RANGE     = 8;
    localparam int EXP_Q         = 28;

    // The table spans [0, SEG_RANGE) and SEG_RANGE is 8, so span = 2^(FRAC_BITS+3).
    localparam int SPAN_SHIFT = FRAC_BITS + $clog2(SEG_RANGE);
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int ROM_IDX_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ROM_W      = FRAC_BITS + 1;
    localparam int MAG_W      = DATA_W + 1;
    localparam int POS_W      = ((MAG_W > SPAN_SHIFT) ? MAG_W : SPAN_SHIFT) + IDX_W + 1;
    localparam int PROD_W     = ROM_W + SPAN_SHIFT;
    localparam int SIG_W      = ROM_W + 1;
    localparam int SAT_W      = (SIG_W > DATA_W) ? SIG_W : DATA_W;

    // Backward datapath widths.
    localparam int OM_W  = ((FRAC_BITS > DATA_W - 1) ? FRAC_BITS : DATA_W - 1) + 2;
    localparam int M1_W  = DATA_W + OM_W;
    localparam int P_W   = M1_W + DATA_W;
    localparam int RND_W = P_W + 1;

    localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
    localparam longint HALF_SPAN = longint'(1) << (SPAN_SHIFT - 1);
    localparam longint HALF_P    = longint'(1) << (2 * FRAC_BITS - 1);
    localparam longint OUT_MAX   = (longint'(1) << (DATA_W - 1)) - 1;
    localparam longint OUT_MIN   = -(longint'(1) << (DATA_W - 1));

    localparam logic [POS_W-1:0] SPAN = POS_W'(1) << SPAN_SHIFT;

    // Codes carried on the operation port.
    typedef enum logic
    {
        OP_FORWARD  = 1'b0,
        OP_BACKWARD = 1'b1
    } op_t;

    // One beat leaving a lane toward the output register.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } lane_out_t;

    typedef logic [ROM_W-1:0] rom_t [TABLE_ENTRIES + 1];

    // Restoring long division; it only runs while the table is built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] numer, input logic [63:0] denom);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], numer[b]};
            if (rem >= {1'b0, denom})
            begin
                rem    = rem - {1'b0, denom};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds the table at elaboration: entry i holds round(2^FRAC_BITS * E/(1+E)) with
    // E = e^(8*i/TABLE_ENTRIES), E taken from a Q28 Taylor series with rounded terms.
    function automatic rom_t sig_rom_build();
        rom_t        rom;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] d;
        logic        stop;
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            num  = 64'(SEG_RANGE * i);
            den  = 64'(TABLE_ENTRIES);
            term = 64'd1 << EXP_Q;
            sum  = term;
            stop = 1'b0;
            for (int n = 1; n <= 200; n++)
            begin
                if (!stop)
                begin
                    d    = den * 64'(n);
                    term = udiv64(term * num + (d >> 1), d);
                    if (term == 64'd0)
                        stop = 1'b1;
                    else
                        sum = sum + term;
                end
            end
            d      = (64'd1 << EXP_Q) + sum;
            rom[i] = ROM_W'(udiv64((sum << FRAC_BITS) + (d >> 1), d));
        end
        return rom;
    endfunction

    localparam rom_t SIG_ROM = sig_rom_build();

endpackage

// ----- rtl/sau_fwd_lane.sv -----
// Forward lane of the sigmoid activation unit: table lookup with linear interpolation.
// Depends on sau_pkg.
module sau_fwd_lane
    import sau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] value,
    output lane_out_t                out_beat
);

    // Stage 1: magnitude, segment index and fraction.
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_neg_reg, s1_neg_next;
    logic                  s1_sat_reg, s1_sat_next;
    logic [IDX_W-1:0]      s1_idx_reg, s1_idx_next;
    logic [SPAN_SHIFT-1:0] s1_fr_reg, s1_fr_next;
    logic signed [MAG_W-1:0] v_ext;
    logic [MAG_W-1:0]      ax;
    logic [POS_W-1:0]      pos;

    always_comb
    begin
        v_ext         = MAG_W'(value);
        s1_neg_next   = value[DATA_W-1];
        ax            = s1_neg_next ? MAG_W'(-v_ext) : MAG_W'(v_ext);
        pos           = POS_W'(ax) * POS_W'(TABLE_ENTRIES);
        s1_sat_next   = (POS_W'(ax) >= SPAN);
        s1_idx_next   = pos[SPAN_SHIFT +: IDX_W];
        s1_fr_next    = pos[SPAN_SHIFT-1:0];
        s1_valid_next = in_valid;
    end

    // Stage 2: table read of both segment ends.
    logic                  s2_valid_reg;
    logic                  s2_neg_reg, s2_sat_reg;
    logic [ROM_W-1:0]      s2_lo_reg, s2_lo_next;
    logic [ROM_W-1:0]      s2_delta_reg, s2_delta_next;
    logic [SPAN_SHIFT-1:0] s2_fr_reg;
    logic [ROM_IDX_W-1:0]  lo_addr;
    logic [ROM_W-1:0]      hi_val;

    always_comb
    begin
        lo_addr       = ROM_IDX_W'(s1_idx_reg);
        s2_lo_next    = SIG_ROM[lo_addr];
        hi_val        = SIG_ROM[lo_addr + ROM_IDX_W'(1)];
        s2_delta_next = (hi_val >= s2_lo_next) ? (hi_val - s2_lo_next) : '0;
    end

    // Stage 3: slope times fraction.
    logic              s3_valid_reg;
    logic              s3_neg_reg, s3_sat_reg;
    logic [ROM_W-1:0]  s3_lo_reg;
    logic [PROD_W-1:0] s3_prod_reg, s3_prod_next;

    assign s3_prod_next = PROD_W'(s2_delta_reg) * PROD_W'(s2_fr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg   <= s1_neg_next;
        s1_sat_reg   <= s1_sat_next;
        s1_idx_reg   <= s1_idx_next;
        s1_fr_reg    <= s1_fr_next;
        s2_neg_reg   <= s1_neg_reg;
        s2_sat_reg   <= s1_sat_reg;
        s2_lo_reg    <= s2_lo_next;
        s2_delta_reg <= s2_delta_next;
        s2_fr_reg    <= s1_fr_reg;
        s3_neg_reg   <= s2_neg_reg;
        s3_sat_reg   <= s2_sat_reg;
        s3_lo_reg    <= s2_lo_reg;
        s3_prod_reg  <= s3_prod_next;
    end

    // Final step: rounding, symmetry for negative inputs and clamp to the output range.
    logic [PROD_W:0]    rnd;
    logic [SIG_W-1:0]   sig;
    logic [SAT_W-1:0]   sig_ext;

    always_comb
    begin
        rnd = (PROD_W + 1)'(s3_prod_reg) + (PROD_W + 1)'(HALF_SPAN);
        sig = SIG_W'(s3_lo_reg) + SIG_W'(rnd >> SPAN_SHIFT);
        if (s3_sat_reg)
            sig = SIG_W'(ONE_Q);
        if (s3_neg_reg)
            sig = SIG_W'(ONE_Q) - sig;
        sig_ext        = SAT_W'(sig);
        out_beat.valid = s3_valid_reg;
        if (sig_ext > SAT_W'(OUT_MAX))
            out_beat.data = DATA_W'(OUT_MAX);
        else
            out_beat.data = DATA_W'(sig_ext);
    end

endmodule

// ----- rtl/sau_bwd_lane.sv -----
// Backward lane of the sigmoid activation unit: a*(1-a)*g with rounding and clamping.
// Depends on sau_pkg.
module sau_bwd_lane
    import sau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] grad,
    output lane_out_t                out_beat
);

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [OM_W-1:0]   om;
    logic signed [M1_W-1:0]   s1_m1_reg, s1_m1_next;
    logic signed [DATA_W-1:0] s1_g_reg;
    logic signed [P_W-1:0]    s2_p_reg, s2_p_next;
    logic signed [RND_W-1:0]  s3_rnd_reg, s3_rnd_next;
    logic signed [RND_W-1:0]  sum;

    always_comb
    begin
        // Stage 1 multiplies the activation by its complement.
        om          = OM_W'(ONE_Q) - OM_W'(value);
        s1_m1_next  = M1_W'(value) * M1_W'(om);
        // Stage 2 applies the upstream gradient.
        s2_p_next   = P_W'(s1_m1_reg) * P_W'(s1_g_reg);
        // Stage 3 rounds to nearest with ties going up.
        sum         = RND_W'(s2_p_reg) + RND_W'(HALF_P);
        s3_rnd_next = sum >>> (2 * FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_m1_reg  <= s1_m1_next;
        s1_g_reg   <= grad;
        s2_p_reg   <= s2_p_next;
        s3_rnd_reg <= s3_rnd_next;
    end

    always_comb
    begin
        out_beat.valid = s3_valid_reg;
        if (s3_rnd_reg > RND_W'(OUT_MAX))
            out_beat.data = DATA_W'(OUT_MAX);
        else if (s3_rnd_reg < RND_W'(OUT_MIN))
            out_beat.data = DATA_W'(OUT_MIN);
        else
            out_beat.data = DATA_W'(s3_rnd_reg);
    end

endmodule

// ----- rtl/sigmoid_activation_unit.sv -----
// Top level of the sigmoid activation unit: forward and backward lanes and the output
// register. Depends on sau_pkg, sau_fwd_lane, sau_bwd_lane and assert_macros.svh.

// The unit takes one beat in every clock cycle: busy is always low, so a beat is taken
// at every edge where start is high. Each beat gives exactly one result, marked by a
// one-cycle done strobe; the receiver cannot stall, so results must be taken as they
// appear. Each result passes through the three register stages of its lane and then
// the output register, and both lanes have the same depth, so results leave in the
// order the beats came in. With operation low the unit returns the logistic sigmoid of
// value, read from a 257-point table over [0, 8] with linear interpolation, mirrored for
// negative inputs, and 1.0 at magnitude 8 before mirroring. With operation high it
// returns value*(1-value)*grad, rounded to nearest with ties going up. All values are
// signed Q4.12, and every result is clamped to the 16-bit signed range.

`include "assert_macros.svh"

module sigmoid_activation_unit
    import sau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] grad,
    output logic signed [DATA_W-1:0] result,
    output logic                     done
);

    lane_out_t fwd_beat;
    lane_out_t bwd_beat;
    logic      fwd_start;
    logic      bwd_start;

    // The pipeline never holds off a new beat.
    assign busy      = 1'b0;
    assign fwd_start = start && (op_t'(operation) == OP_FORWARD);
    assign bwd_start = start && (op_t'(operation) == OP_BACKWARD);

    sau_fwd_lane u_fwd
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fwd_start),
        .value    (value),
        .out_beat (fwd_beat)
    );

    sau_bwd_lane u_bwd
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bwd_start),
        .value    (value),
        .grad     (grad),
        .out_beat (bwd_beat)
    );

    // Output register. At most one lane holds a valid beat in any cycle, since each
    // input beat enters exactly one lane and both lanes are equally deep.
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] result_reg, result_next;

    always_comb
    begin
        done_next   = fwd_beat.valid || bwd_beat.valid;
        result_next = fwd_beat.valid ? fwd_beat.data : bwd_beat.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SAU_ASSERT(a_start_gives_done, start |-> ##4 done, "accepted beat did not produce a result")
    `SAU_ASSERT(a_done_has_start, done |-> $past(start, 4), "result strobe without an accepted beat")
    `SAU_ASSERT_NEVER(a_lanes_collide, fwd_beat.valid && bwd_beat.valid, "both lanes valid")
    `SAU_ASSERT(a_fwd_nonneg, (done && $past(fwd_start, 4)) |-> !result[DATA_W-1], "negative sigmoid output")

endmodule

// ----- verif/tb_sigmoid_activation_unit.sv -----
// Self-checking testbench for sigmoid_activation_unit: forward sigmoid and backward
// gradient beats, checked against an in-bench predictor. Depends on sau_pkg and the RTL.

module tb_sigmoid_activation_unit;

    import sau_pkg::*;

    // Q28 scale of the exponential series used to build the lookup table.
    localparam int EXP_FRAC = 28;

    // Q4.12 constants used by the directed tests.
    localparam logic signed [DATA_W-1:0] Q_ONE  = 16'sd4096;
    localparam logic signed [DATA_W-1:0] Q_HALF = 16'sd2048;
    localparam logic signed [DATA_W-1:0] Q_MAX  = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 16'sh8000;

    // Bound on the cycles spent waiting for the last results after the stimulus ends.
    localparam int DRAIN_LIMIT = 2000;

    // One expected result, kept together with the beat that caused it so that a
    // mismatch report can say which input went wrong.
    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] g_in;
        logic signed [DATA_W-1:0] result;
    } sigmoid_expect_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] result;
    logic                     done;

    // Sigmoid samples at x_i = 8*i/TABLE_ENTRIES, in Q(FRAC_BITS).
    longint          logistic_lut [TABLE_ENTRIES + 1];
    sigmoid_expect_t pending_results [$];
    int              mismatch_count = 0;

    sigmoid_activation_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .value     (value),
        .grad      (grad),
        .result    (result),
        .done      (done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fills the lookup table: e^x is summed as a Taylor series in Q28 with each term
    // rounded half up, stopping at the first term that rounds to zero. The entry is
    // then e/(1+e) rounded half up to FRAC_BITS fraction bits.
    function automatic void build_logistic_lut();
        logic [63:0] term;
        logic [63:0] total;
        logic [63:0] divisor;
        logic [63:0] denom;
        logic        settled;
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            term    = 64'd1 << EXP_FRAC;
            total   = term;
            settled = 1'b0;
            for (int n = 1; n <= 200; n++)
            begin
                if (!settled)
                begin
                    divisor = 64'(TABLE_ENTRIES) * 64'(n);
                    term    = (term * 64'(SEG_RANGE * i) + divisor / 2) / divisor;
                    if (term == 64'd0)
                        settled = 1'b1;
                    else
                        total = total + term;
                end
            end
            denom           = (64'd1 << EXP_FRAC) + total;
            logistic_lut[i] = longint'(((total << FRAC_BITS) + denom / 2) / denom);
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[DATA_W-1:0];
    endfunction

    // Interpolated sigmoid of x. Magnitudes of 8.0 and above give exactly 1.0, and
    // negative inputs are mirrored through s(-x) = 1 - s(x).
    function automatic logic signed [DATA_W-1:0] logistic_of(
        input logic signed [DATA_W-1:0] x);
        longint xv;
        longint mag;
        longint span;
        longint one;
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        longint delta;
        longint s;
        xv   = x;
        mag  = (xv < 0) ? -xv : xv;
        span = longint'(SEG_RANGE) << FRAC_BITS;
        one  = longint'(1) << FRAC_BITS;
        if (mag >= span)
            s = one;
        else
        begin
            pos  = mag * TABLE_ENTRIES;
            idx  = pos / span;
            frac = pos % span;
            if (idx >= TABLE_ENTRIES)
            begin
                idx  = TABLE_ENTRIES - 1;
                frac = span;
            end
            lo    = logistic_lut[idx];
            hi    = logistic_lut[idx + 1];
            delta = (hi >= lo) ? hi - lo : 0;
            s     = lo + (delta * frac + span / 2) / span;
        end
        if (xv < 0)
            s = one - s;
        return clamp_q(s);
    endfunction

    // a*(1-a)*g is exact in 64 bits; the arithmetic shift floors, so adding half an
    // output step first rounds to nearest with ties going up, for either sign.
    function automatic logic signed [DATA_W-1:0] logistic_grad_of(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] g);
        longint av;
        longint gv;
        longint prod;
        av   = a;
        gv   = g;
        prod = av * ((longint'(1) << FRAC_BITS) - av) * gv;
        return clamp_q((prod + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS));
    endfunction

    // Gap after a beat: mostly none or a few cycles, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // Drives one beat, holds it until the unit takes it, records the expected result
    // and then idles for the given number of cycles. While idle, the data ports carry
    // noise that the unit must ignore. start is only lowered when a gap follows, so a
    // beat that is sent straight after keeps it high without a glitch.
    task automatic send_beat(
        input logic                     op,
        input logic signed [DATA_W-1:0] x,
        input logic signed [DATA_W-1:0] g,
        input int unsigned              gap);
        sigmoid_expect_t e;
        start     <= 1'b1;
        operation <= op;
        value     <= x;
        grad      <= g;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        e.op     = op;
        e.x_in   = x;
        e.g_in   = g;
        e.result = (op == OP_BACKWARD) ? logistic_grad_of(x, g) : logistic_of(x);
        pending_results.push_back(e);
        if (gap != 0)
        begin
            start     <= 1'b0;
            operation <= 1'($urandom);
            value     <= 16'($urandom);
            grad      <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Every done strobe must match the oldest outstanding expectation. Outputs are
    // sampled at the edge that ends the strobe cycle, before the unit updates them.
    always @(posedge clk)
    begin
        sigmoid_expect_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %0d with nothing outstanding",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (result !== e.result)
                begin
                    $display("%0t: result mismatch (op %0d value %0d grad %0d) expected %0d actual %0d",
                             $time, e.op, e.x_in, e.g_in, e.result, result);
                    mismatch_count++;
                end
            end
        end
    end

    // Forward corners: zero, unit steps, exact table points, the last segment, both
    // ends of the input range and the one input that reaches the saturated region.
    // grad carries noise here, since forward mode must ignore it.
    task automatic test_forward_corners();
        send_beat(OP_FORWARD, 16'sd0, Q_MAX, idle_gap());
        send_beat(OP_FORWARD, Q_ONE, Q_MIN, idle_gap());
        send_beat(OP_FORWARD, -Q_ONE, 16'sd0, idle_gap());
        send_beat(OP_FORWARD, 16'sd1, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, -16'sd1, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, 16'sd128, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, 16'sd127, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, 16'sd32640, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, Q_MAX, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, -16'sd32767, 16'($urandom), idle_gap());
        send_beat(OP_FORWARD, Q_MIN, 16'($urandom), idle_gap());
    endtask

    // Backward corners: activations at 0, 1/2 and 1, activations outside [0,1] that
    // drive the product past the output range in both directions, a zero gradient,
    // and small products that land on rounding ties of either sign.
    task automatic test_backward_corners();
        send_beat(OP_BACKWARD, 16'sd0, Q_MAX, idle_gap());
        send_beat(OP_BACKWARD, Q_ONE, Q_MIN, idle_gap());
        send_beat(OP_BACKWARD, Q_HALF, Q_MAX, idle_gap());
        send_beat(OP_BACKWARD, Q_HALF, Q_MIN, idle_gap());
        send_beat(OP_BACKWARD, Q_MIN, Q_MIN, idle_gap());
        send_beat(OP_BACKWARD, Q_MIN, Q_MAX, idle_gap());
        send_beat(OP_BACKWARD, Q_MAX, 16'sd1, idle_gap());
        send_beat(OP_BACKWARD, 16'sd1234, 16'sd0, idle_gap());
        send_beat(OP_BACKWARD, Q_HALF, 16'sd2, idle_gap());
        send_beat(OP_BACKWARD, Q_HALF, -16'sd2, idle_gap());
        send_beat(OP_BACKWARD, 16'sd1, 16'sd1, idle_gap());
    endtask

    // Mostly in-range traffic: forward inputs within the table range, backward
    // activations within [0,1]. A quarter of the beats use any 16-bit pattern.
    task automatic test_random_mix(input int beats);
        logic                     op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] g;
        for (int k = 0; k < beats; k++)
        begin
            op = 1'($urandom);
            g  = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                x = 16'($urandom);
            else if (op == OP_FORWARD)
                x = 16'(16'($urandom_range(0, 32767)) *
                        (($urandom_range(0, 1) != 0) ? -1 : 1));
            else
                x = 16'($urandom_range(0, 4096));
            send_beat(op, x, g, idle_gap());
        end
    endtask

    // A long run with a beat on every clock, so the pipeline is full throughout.
    task automatic test_streaming_burst(input int beats);
        for (int k = 0; k < beats; k++)
            send_beat(1'($urandom), 16'($urandom), 16'($urandom), 0);
    endtask

    initial
    begin
        int drain_cycles;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_FORWARD;
        value     <= '0;
        grad      <= '0;
        build_logistic_lut();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_forward_corners();
        test_backward_corners();
        test_random_mix(390);
        test_streaming_burst(60);
        start <= 1'b0;

        // Let the pipeline empty, then give it a few more cycles so that any stray
        // strobe would still be caught.
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            mismatch_count++;
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: stops a run that hangs and reports it as a failure.
    initial
    begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
